FILE: src/bhrc_pkg.sv
// shared constants and types for the bcube hop route calculator
package bhrc_pkg;

    localparam int SERVER_W = 16;
    localparam int LEVEL_W  = 2;
    localparam int SWITCH_W = 14;
    localparam int LINK_W   = 18;
    localparam int RADIX_W  = 5;
    localparam int TOP_W    = 2;
    localparam int APB_W    = 32;
    localparam int ADDR_W   = 3;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd4;
    localparam logic [TOP_W-1:0]   TOP_RESET   = 2'd1;

    typedef enum logic
    {
        REG_RADIX     = 1'b0,
        REG_TOP_LEVEL = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic range_error;
        logic no_route;
    } route_flags_t;

endpackage

FILE: src/bhrc_front.sv
// front end: clamps the configuration, looks up the reciprocal, classifies the beat
module bhrc_front
    import bhrc_pkg::*;
#(
    parameter int MAX_DIGITS = 4,
    parameter int MAX_RADIX  = 16,
    localparam int NW  = $clog2(MAX_RADIX + 1),
    localparam int KW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
    localparam int RSH = SERVER_W + $clog2(MAX_RADIX)
)
(
    input  logic                start,
    input  logic                full,
    input  logic [SERVER_W-1:0] src_server,
    input  logic [SERVER_W-1:0] dst_server,
    input  logic [RADIX_W-1:0]  radix,
    input  logic [TOP_W-1:0]    top_level,
    output logic                push,
    output logic [SERVER_W-1:0] q_src,
    output logic [SERVER_W-1:0] q_dst,
    output logic [NW-1:0]       q_radix,
    output logic [KW-1:0]       q_top,
    output logic [RSH-1:0]      q_recip,
    output logic                q_same
);

    localparam int CW = (NW > RADIX_W) ? NW : RADIX_W;
    localparam int TW = (KW > TOP_W) ? KW : TOP_W;

    logic [RSH-1:0] recip_tab [MAX_RADIX + 1];
    logic [CW-1:0]  radix_ext;
    logic [TW-1:0]  top_ext;

    // ceil(2^RSH / n), exact quotient for any 16-bit dividend
    for (genvar g = 0; g <= MAX_RADIX; g++)
    begin : g_recip
        localparam longint DIV = (g < 2) ? 1 : g;
        localparam longint VAL = ((longint'(1) << RSH) + DIV - 1) / DIV;
        assign recip_tab[g] = RSH'(VAL);
    end

    always_comb
    begin
        radix_ext = CW'(radix);
        top_ext   = TW'(top_level);
        if (radix_ext < CW'(2))
        begin
            q_radix = NW'(2);
        end
        else if (radix_ext > CW'(MAX_RADIX))
        begin
            q_radix = NW'(MAX_RADIX);
        end
        else
        begin
            q_radix = NW'(radix_ext);
        end
        if (top_ext > TW'(MAX_DIGITS - 1))
        begin
            q_top = KW'(MAX_DIGITS - 1);
        end
        else
        begin
            q_top = KW'(top_ext);
        end
    end

    assign q_recip = recip_tab[q_radix];
    assign push    = start & ~full;
    assign q_src   = src_server;
    assign q_dst   = dst_server;
    assign q_same  = (src_server == dst_server);

endmodule

FILE: src/bhrc_queue.sv
// small fifo between the front end and the route pipeline
module bhrc_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             rd_valid,
    output logic [WIDTH-1:0] dout,
    output logic             full
);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // the pipeline behind never stalls, so the head leaves every cycle
    assign rd_valid = (count_reg != '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign do_push  = push & ~full;
    assign do_pop   = rd_valid;
    assign dout     = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: src/bhrc_back.sv
// back end: digit split pipeline, level search, switch and link arithmetic
module bhrc_back
    import bhrc_pkg::*;
#(
    parameter int MAX_DIGITS = 4,
    parameter int MAX_RADIX  = 16,
    localparam int NW  = $clog2(MAX_RADIX + 1),
    localparam int KW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
    localparam int RSH = SERVER_W + $clog2(MAX_RADIX)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [SERVER_W-1:0] in_src,
    input  logic [SERVER_W-1:0] in_dst,
    input  logic [NW-1:0]       in_radix,
    input  logic [KW-1:0]       in_top,
    input  logic [RSH-1:0]      in_recip,
    input  logic                in_same,
    output logic                done,
    output logic [LEVEL_W-1:0]  route_level,
    output logic [SWITCH_W-1:0] switch_index,
    output logic [LINK_W-1:0]   up_link,
    output logic [LINK_W-1:0]   down_link,
    output logic                no_route,
    output logic                range_error
);

    localparam int D  = MAX_DIGITS;
    localparam int NS = 2 * D;
    localparam int L  = NS - 1;
    localparam int DW = $clog2(MAX_RADIX);
    localparam int PW = SERVER_W + RSH;

    logic                         vld_reg  [NS];
    logic [SERVER_W-1:0]          src_reg  [NS];
    logic [NW-1:0]                n_reg    [NS];
    logic [KW-1:0]                k_reg    [NS];
    logic [RSH-1:0]               m_reg    [NS];
    logic                         same_reg [NS];
    logic [SERVER_W-1:0]          cs_reg   [NS];
    logic [SERVER_W-1:0]          cd_reg   [NS];
    logic [D-1:0][SERVER_W-1:0]   qs_reg   [NS];
    logic [D-1:0][SERVER_W-1:0]   qd_reg   [NS];
    logic [D-1:0][DW-1:0]         ds_reg   [NS];
    logic [D-1:0][DW-1:0]         dd_reg   [NS];
    logic [D-1:0][LINK_W-1:0]     pw_reg   [NS];
    logic [PW-1:0]                prod_s_reg [D];
    logic [PW-1:0]                prod_d_reg [D];

    for (genvar i = 0; i < D; i++)
    begin : g_digit
        logic                       a_vld;
        logic [SERVER_W-1:0]        a_src;
        logic [NW-1:0]              a_n;
        logic [KW-1:0]              a_k;
        logic [RSH-1:0]             a_m;
        logic                       a_same;
        logic [SERVER_W-1:0]        a_cs;
        logic [SERVER_W-1:0]        a_cd;
        logic [D-1:0][SERVER_W-1:0] a_qs;
        logic [D-1:0][SERVER_W-1:0] a_qd;
        logic [D-1:0][DW-1:0]       a_ds;
        logic [D-1:0][DW-1:0]       a_dd;
        logic [D-1:0][LINK_W-1:0]   a_pw;
        logic [D-1:0][LINK_W-1:0]   pw_next;
        logic [SERVER_W-1:0]        b_qs;
        logic [SERVER_W-1:0]        b_qd;
        logic [SERVER_W+NW-1:0]     b_qns;
        logic [SERVER_W+NW-1:0]     b_qnd;
        logic [SERVER_W-1:0]        b_rs;
        logic [SERVER_W-1:0]        b_rd;
        logic [D-1:0][SERVER_W-1:0] qs_next;
        logic [D-1:0][SERVER_W-1:0] qd_next;
        logic [D-1:0][DW-1:0]       ds_next;
        logic [D-1:0][DW-1:0]       dd_next;

        if (i == 0)
        begin : g_first
            always_comb
            begin
                a_vld   = in_valid;
                a_src   = in_src;
                a_n     = in_radix;
                a_k     = in_top;
                a_m     = in_recip;
                a_same  = in_same;
                a_cs    = in_src;
                a_cd    = in_dst;
                a_qs    = '0;
                a_qd    = '0;
                a_ds    = '0;
                a_dd    = '0;
                a_pw    = '0;
                a_pw[0] = LINK_W'(1);
            end
        end
        else
        begin : g_chain
            always_comb
            begin
                a_vld  = vld_reg[2*i-1];
                a_src  = src_reg[2*i-1];
                a_n    = n_reg[2*i-1];
                a_k    = k_reg[2*i-1];
                a_m    = m_reg[2*i-1];
                a_same = same_reg[2*i-1];
                a_cs   = cs_reg[2*i-1];
                a_cd   = cd_reg[2*i-1];
                a_qs   = qs_reg[2*i-1];
                a_qd   = qd_reg[2*i-1];
                a_ds   = ds_reg[2*i-1];
                a_dd   = dd_reg[2*i-1];
                a_pw   = pw_reg[2*i-1];
            end
        end

        // next power of the radix rides along with the quotient multiply
        if (i + 1 < D)
        begin : g_pow
            always_comb
            begin
                pw_next        = a_pw;
                pw_next[i + 1] = LINK_W'(a_pw[i] * a_n);
            end
        end
        else
        begin : g_pow_last
            assign pw_next = a_pw;
        end

        always_comb
        begin
            b_qs       = prod_s_reg[i][PW-1:RSH];
            b_qd       = prod_d_reg[i][PW-1:RSH];
            b_qns      = b_qs * n_reg[2*i];
            b_qnd      = b_qd * n_reg[2*i];
            b_rs       = cs_reg[2*i] - b_qns[SERVER_W-1:0];
            b_rd       = cd_reg[2*i] - b_qnd[SERVER_W-1:0];
            qs_next    = qs_reg[2*i];
            qs_next[i] = b_qs;
            qd_next    = qd_reg[2*i];
            qd_next[i] = b_qd;
            ds_next    = ds_reg[2*i];
            ds_next[i] = b_rs[DW-1:0];
            dd_next    = dd_reg[2*i];
            dd_next[i] = b_rd[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[2*i]   <= 1'b0;
                vld_reg[2*i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[2*i]   <= a_vld;
                vld_reg[2*i+1] <= vld_reg[2*i];
            end
        end

        // reciprocal multiply
        always_ff @(posedge clk)
        begin
            src_reg[2*i]  <= a_src;
            n_reg[2*i]    <= a_n;
            k_reg[2*i]    <= a_k;
            m_reg[2*i]    <= a_m;
            same_reg[2*i] <= a_same;
            cs_reg[2*i]   <= a_cs;
            cd_reg[2*i]   <= a_cd;
            qs_reg[2*i]   <= a_qs;
            qd_reg[2*i]   <= a_qd;
            ds_reg[2*i]   <= a_ds;
            dd_reg[2*i]   <= a_dd;
            pw_reg[2*i]   <= pw_next;
            prod_s_reg[i] <= a_cs * a_m;
            prod_d_reg[i] <= a_cd * a_m;
        end

        // quotient and remainder digit
        always_ff @(posedge clk)
        begin
            src_reg[2*i+1]  <= src_reg[2*i];
            n_reg[2*i+1]    <= n_reg[2*i];
            k_reg[2*i+1]    <= k_reg[2*i];
            m_reg[2*i+1]    <= m_reg[2*i];
            same_reg[2*i+1] <= same_reg[2*i];
            cs_reg[2*i+1]   <= b_qs;
            cd_reg[2*i+1]   <= b_qd;
            qs_reg[2*i+1]   <= qs_next;
            qd_reg[2*i+1]   <= qd_next;
            ds_reg[2*i+1]   <= ds_next;
            dd_reg[2*i+1]   <= dd_next;
            pw_reg[2*i+1]   <= pw_reg[2*i];
        end
    end

    // level search and operand select
    logic                sel_vld_reg;
    logic [KW-1:0]       sel_lvl_reg;
    logic [SERVER_W-1:0] sel_qlo_reg;
    logic [SERVER_W-1:0] sel_qhi_reg;
    logic [LINK_W-1:0]   sel_pl_reg;
    logic [LINK_W-1:0]   sel_pk_reg;
    logic [SERVER_W-1:0] sel_src_reg;
    logic [NW-1:0]       sel_n_reg;
    logic [DW-1:0]       sel_ds_reg;
    logic [DW-1:0]       sel_dd_reg;
    route_flags_t        sel_flags_reg;

    logic [KW-1:0]       c_lvl;
    route_flags_t        c_flags;
    logic                c_range;
    logic [SERVER_W-1:0] c_qlo;

    always_comb
    begin
        c_range = (qs_reg[L][k_reg[L]] != '0) || (qd_reg[L][k_reg[L]] != '0);
        c_lvl   = '0;
        for (int j = D - 1; j >= 0; j--)
        begin
            if (ds_reg[L][j] != dd_reg[L][j])
            begin
                c_lvl = KW'(j);
            end
        end
        c_qlo = (c_lvl == '0) ? src_reg[L] : qs_reg[L][c_lvl - KW'(1)];
        c_flags.range_error = c_range;
        c_flags.no_route    = ~c_range & same_reg[L];
    end

    always_ff @(posedge clk)
    begin
        sel_lvl_reg   <= c_lvl;
        sel_qlo_reg   <= c_qlo;
        sel_qhi_reg   <= qs_reg[L][c_lvl];
        sel_pl_reg    <= pw_reg[L][c_lvl];
        sel_pk_reg    <= pw_reg[L][k_reg[L]];
        sel_src_reg   <= src_reg[L];
        sel_n_reg     <= n_reg[L];
        sel_ds_reg    <= ds_reg[L][c_lvl];
        sel_dd_reg    <= dd_reg[L][c_lvl];
        sel_flags_reg <= c_flags;
    end

    // partial products of the switch index
    logic                mul_vld_reg;
    logic [LINK_W-1:0]   mul_lo_reg;
    logic [LINK_W-1:0]   mul_hi_reg;
    logic [LINK_W-1:0]   mul_top_reg;
    logic [KW-1:0]       mul_lvl_reg;
    logic [SERVER_W-1:0] mul_src_reg;
    logic [NW-1:0]       mul_n_reg;
    logic [DW-1:0]       mul_ds_reg;
    logic [DW-1:0]       mul_dd_reg;
    route_flags_t        mul_flags_reg;

    always_ff @(posedge clk)
    begin
        mul_lo_reg    <= LINK_W'(sel_qlo_reg * sel_pl_reg);
        mul_hi_reg    <= LINK_W'(sel_qhi_reg * sel_pl_reg);
        mul_top_reg   <= LINK_W'(LINK_W'(sel_lvl_reg) * sel_pk_reg);
        mul_lvl_reg   <= sel_lvl_reg;
        mul_src_reg   <= sel_src_reg;
        mul_n_reg     <= sel_n_reg;
        mul_ds_reg    <= sel_ds_reg;
        mul_dd_reg    <= sel_dd_reg;
        mul_flags_reg <= sel_flags_reg;
    end

    // switch = level*n^k + low digits + high digits shifted down one place
    logic                sum_vld_reg;
    logic [LINK_W-1:0]   sum_sw_reg;
    logic [KW-1:0]       sum_lvl_reg;
    logic [NW-1:0]       sum_n_reg;
    logic [DW-1:0]       sum_ds_reg;
    logic [DW-1:0]       sum_dd_reg;
    route_flags_t        sum_flags_reg;

    always_ff @(posedge clk)
    begin
        sum_sw_reg    <= mul_top_reg + mul_hi_reg - mul_lo_reg + LINK_W'(mul_src_reg);
        sum_lvl_reg   <= mul_lvl_reg;
        sum_n_reg     <= mul_n_reg;
        sum_ds_reg    <= mul_ds_reg;
        sum_dd_reg    <= mul_dd_reg;
        sum_flags_reg <= mul_flags_reg;
    end

    // link indices and output register
    logic                done_reg;
    logic [LEVEL_W-1:0]  route_level_reg;
    logic [SWITCH_W-1:0] switch_index_reg;
    logic [LINK_W-1:0]   up_link_reg;
    logic [LINK_W-1:0]   down_link_reg;
    route_flags_t        flags_reg;
    logic [LINK_W-1:0]   link_base;
    logic                any_flag;

    assign link_base = LINK_W'(sum_sw_reg * sum_n_reg);
    assign any_flag  = sum_flags_reg.range_error | sum_flags_reg.no_route;

    always_ff @(posedge clk)
    begin
        flags_reg <= sum_flags_reg;
        if (any_flag)
        begin
            route_level_reg  <= '0;
            switch_index_reg <= '0;
            up_link_reg      <= '0;
            down_link_reg    <= '0;
        end
        else
        begin
            route_level_reg  <= LEVEL_W'(sum_lvl_reg);
            switch_index_reg <= sum_sw_reg[SWITCH_W-1:0];
            up_link_reg      <= link_base + LINK_W'(sum_ds_reg);
            down_link_reg    <= link_base + LINK_W'(sum_dd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_vld_reg <= 1'b0;
            mul_vld_reg <= 1'b0;
            sum_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            sel_vld_reg <= vld_reg[L];
            mul_vld_reg <= sel_vld_reg;
            sum_vld_reg <= mul_vld_reg;
            done_reg    <= sum_vld_reg;
        end
    end

    assign done         = done_reg;
    assign route_level  = route_level_reg;
    assign switch_index = switch_index_reg;
    assign up_link      = up_link_reg;
    assign down_link    = down_link_reg;
    assign no_route     = flags_reg.no_route;
    assign range_error  = flags_reg.range_error;

endmodule

FILE: src/bcube_hop_route_calc.sv
// top level of the bcube single hop route calculator
//
// a request beat (src_server, dst_server) is taken at a rising edge with start
// high and busy low. one result beat per request comes back on the result
// ports, marked by done for exactly one cycle, in request order.
// after the accepting edge a request passes the fifo, then two stages per
// address digit (reciprocal multiply, then quotient and remainder), then
// level select, partial products, switch sum and link index.
// a new request can be taken every cycle; the route pipeline never stalls,
// so the fifo between the classifier and the pipeline drains each cycle and
// busy stays low.
// radix and top_level are at apb byte addresses 0 and 4; out of range values
// are clamped; users write them while no request is in flight (unchecked).
// reset clears the pipeline and the fifo and loads radix 4, top_level 1.
// the result side has no back-pressure: done is a strobe and must be taken.
module bcube_hop_route_calc
    import bhrc_pkg::*;
#(
    parameter int MAX_DIGITS = 4,
    parameter int MAX_RADIX  = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]    prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic [SERVER_W-1:0] src_server,
    input  logic [SERVER_W-1:0] dst_server,
    output logic                done,
    output logic [LEVEL_W-1:0]  route_level,
    output logic [SWITCH_W-1:0] switch_index,
    output logic [LINK_W-1:0]   up_link,
    output logic [LINK_W-1:0]   down_link,
    output logic                no_route,
    output logic                range_error
);

    localparam int NW  = $clog2(MAX_RADIX + 1);
    localparam int KW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int RSH = SERVER_W + $clog2(MAX_RADIX);
    localparam int EW  = 2 * SERVER_W + NW + KW + RSH + 1;

    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [TOP_W-1:0]   top_level_reg, top_level_next;
    logic               cfg_write;
    cfg_reg_t           cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_sel   = cfg_reg_t'(paddr[2]);

    always_comb
    begin
        radix_next     = radix_reg;
        top_level_next = top_level_reg;
        prdata         = '0;
        case (cfg_sel)
            REG_RADIX:
            begin
                prdata = APB_W'(radix_reg);
                if (cfg_write)
                begin
                    radix_next = pwdata[RADIX_W-1:0];
                end
            end
            REG_TOP_LEVEL:
            begin
                prdata = APB_W'(top_level_reg);
                if (cfg_write)
                begin
                    top_level_next = pwdata[TOP_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= RADIX_RESET;
            top_level_reg <= TOP_RESET;
        end
        else
        begin
            radix_reg     <= radix_next;
            top_level_reg <= top_level_next;
        end
    end

    logic                push;
    logic                q_full;
    logic                q_valid;
    logic [SERVER_W-1:0] f_src;
    logic [SERVER_W-1:0] f_dst;
    logic [NW-1:0]       f_radix;
    logic [KW-1:0]       f_top;
    logic [RSH-1:0]      f_recip;
    logic                f_same;
    logic [EW-1:0]       q_din;
    logic [EW-1:0]       q_dout;
    logic [SERVER_W-1:0] b_src;
    logic [SERVER_W-1:0] b_dst;
    logic [NW-1:0]       b_radix;
    logic [KW-1:0]       b_top;
    logic [RSH-1:0]      b_recip;
    logic                b_same;

    bhrc_front #(
        .MAX_DIGITS (MAX_DIGITS),
        .MAX_RADIX  (MAX_RADIX)
    ) u_front (
        .start      (start),
        .full       (q_full),
        .src_server (src_server),
        .dst_server (dst_server),
        .radix      (radix_reg),
        .top_level  (top_level_reg),
        .push       (push),
        .q_src      (f_src),
        .q_dst      (f_dst),
        .q_radix    (f_radix),
        .q_top      (f_top),
        .q_recip    (f_recip),
        .q_same     (f_same)
    );

    assign q_din = {f_src, f_dst, f_radix, f_top, f_recip, f_same};

    bhrc_queue #(
        .WIDTH (EW),
        .DEPTH (2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .din      (q_din),
        .rd_valid (q_valid),
        .dout     (q_dout),
        .full     (q_full)
    );

    assign {b_src, b_dst, b_radix, b_top, b_recip, b_same} = q_dout;
    assign busy = q_full;

    bhrc_back #(
        .MAX_DIGITS (MAX_DIGITS),
        .MAX_RADIX  (MAX_RADIX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_src       (b_src),
        .in_dst       (b_dst),
        .in_radix     (b_radix),
        .in_top       (b_top),
        .in_recip     (b_recip),
        .in_same      (b_same),
        .done         (done),
        .route_level  (route_level),
        .switch_index (switch_index),
        .up_link      (up_link),
        .down_link    (down_link),
        .no_route     (no_route),
        .range_error  (range_error)
    );

    a_never_full: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("route fifo filled up");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(no_route && range_error))
        else $error("both no_route and range_error set");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (no_route || range_error) |->
            route_level == '0 && switch_index == '0 && up_link == '0 && down_link == '0)
        else $error("flagged result carries a route");

endmodule

FILE: verif/tb.sv
// self-checking testbench for the bcube hop route calculator with apb register setup
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bhrc_pkg::*;

    localparam int MAX_DIGITS = 4;
    localparam int MAX_RADIX  = 16;
    localparam int LATENCY    = 2 * MAX_DIGITS + 4;
    localparam int PHASES     = 10;
    localparam int PER_PHASE  = 144;

    typedef struct packed
    {
        logic [SERVER_W-1:0] src;
        logic [SERVER_W-1:0] dst;
    } hop_req_t;

    typedef struct packed
    {
        logic [LEVEL_W-1:0]  level;
        logic [SWITCH_W-1:0] sw;
        logic [LINK_W-1:0]   up;
        logic [LINK_W-1:0]   down;
        logic                no_route;
        logic                range_error;
    } route_t;

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [APB_W-1:0]    pwdata  = '0;
    logic [APB_W-1:0]    prdata;
    logic                pready;
    logic                start   = 1'b0;
    logic                busy;
    logic [SERVER_W-1:0] src_server = '0;
    logic [SERVER_W-1:0] dst_server = '0;
    logic                done;
    logic [LEVEL_W-1:0]  route_level;
    logic [SWITCH_W-1:0] switch_index;
    logic [LINK_W-1:0]   up_link;
    logic [LINK_W-1:0]   down_link;
    logic                no_route;
    logic                range_error;

    logic [RADIX_W-1:0]  cfg_radix = RADIX_RESET;
    logic [TOP_W-1:0]    cfg_top   = TOP_RESET;
    int unsigned         idle_pct  = 10;
    int unsigned         mismatches = 0;

    hop_req_t req_q[$];
    route_t   route_q[$];

    bcube_hop_route_calc
    #(
        .MAX_DIGITS (MAX_DIGITS),
        .MAX_RADIX  (MAX_RADIX)
    )
    i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .src_server   (src_server),
        .dst_server   (dst_server),
        .done         (done),
        .route_level  (route_level),
        .switch_index (switch_index),
        .up_link      (up_link),
        .down_link    (down_link),
        .no_route     (no_route),
        .range_error  (range_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned eff_radix();
        if (cfg_radix < 2)
            return 2;
        if (cfg_radix > MAX_RADIX)
            return MAX_RADIX;
        return cfg_radix;
    endfunction

    function automatic int unsigned eff_digits();
        if (cfg_top > MAX_DIGITS - 1)
            return MAX_DIGITS;
        return cfg_top + 1;
    endfunction

    function automatic int unsigned server_limit();
        int unsigned lim;
        lim = 1;
        for (int i = 0; i < eff_digits(); i++)
            lim = lim * eff_radix();
        return lim;
    endfunction

    function automatic route_t route_of(logic [SERVER_W-1:0] src, logic [SERVER_W-1:0] dst);
        int unsigned n;
        int unsigned digits;
        int unsigned lim;
        int unsigned lvl;
        int unsigned sw;
        int unsigned s;
        int unsigned d;
        int unsigned sd[MAX_DIGITS];
        int unsigned dd[MAX_DIGITS];
        route_t r;
        r = '0;
        n = eff_radix();
        digits = eff_digits();
        lim = server_limit();
        if (src >= lim || dst >= lim)
        begin
            r.range_error = 1'b1;
            return r;
        end
        if (src == dst)
        begin
            r.no_route = 1'b1;
            return r;
        end
        s = src;
        d = dst;
        for (int i = 0; i < digits; i++)
        begin
            sd[i] = s % n;
            dd[i] = d % n;
            s = s / n;
            d = d / n;
        end
        lvl = 0;
        for (int i = digits - 1; i >= 0; i--)
            if (sd[i] != dd[i])
                lvl = i;
        sw = lvl;
        for (int p = digits - 1; p >= 0; p--)
            if (p != lvl)
                sw = sw * n + sd[p];
        r.level = LEVEL_W'(lvl);
        r.sw    = SWITCH_W'(sw);
        r.up    = LINK_W'(sw * n + sd[lvl]);
        r.down  = LINK_W'(sw * n + dd[lvl]);
        return r;
    endfunction

    function automatic hop_req_t make_req();
        int unsigned n;
        int unsigned digits;
        int unsigned lim;
        int unsigned lvl;
        int unsigned pick;
        int unsigned s;
        int unsigned d;
        int unsigned sd[MAX_DIGITS];
        int unsigned dd[MAX_DIGITS];
        hop_req_t q;
        n = eff_radix();
        digits = eff_digits();
        lim = server_limit();
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            q.src = SERVER_W'($urandom_range(lim - 1));
            q.dst = q.src;
        end
        else if (pick < 18)
        begin
            q.src = SERVER_W'($urandom);
            q.dst = SERVER_W'($urandom);
        end
        else if (pick < 26 && lim < 65536)
        begin
            q.src = SERVER_W'($urandom_range(65535, lim));
            q.dst = SERVER_W'($urandom_range(lim - 1));
            if ($urandom_range(1))
                q = {q.dst, q.src};
            if ($urandom_range(3) == 0)
                q.dst = SERVER_W'($urandom_range(65535, lim));
        end
        else
        begin
            for (int i = 0; i < digits; i++)
            begin
                sd[i] = $urandom_range(n - 1);
                dd[i] = sd[i];
            end
            lvl = $urandom_range(digits - 1);
            dd[lvl] = (sd[lvl] + 1 + $urandom_range(n - 2)) % n;
            for (int p = lvl + 1; p < digits; p++)
                if ($urandom_range(1))
                    dd[p] = $urandom_range(n - 1);
            s = 0;
            d = 0;
            for (int p = digits - 1; p >= 0; p--)
            begin
                s = s * n + sd[p];
                d = d * n + dd[p];
            end
            q.src = SERVER_W'(s);
            q.dst = SERVER_W'(d);
        end
        return q;
    endfunction

    task automatic note_fail(string msg, route_t want, route_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: exp lvl=%0d sw=%0d up=%0d down=%0d nr=%0b re=%0b, %s",
                     $realtime, msg, want.level, want.sw, want.up, want.down,
                     want.no_route, want.range_error,
                     $sformatf("got lvl=%0d sw=%0d up=%0d down=%0d nr=%0b re=%0b",
                               got.level, got.sw, got.up, got.down, got.no_route,
                               got.range_error));
    endtask

    task automatic cfg_write(cfg_reg_t r, int unsigned v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= APB_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == REG_RADIX)
            cfg_radix = RADIX_W'(v);
        else
            cfg_top = TOP_W'(v);
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || start || route_q.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            req_q.push_back(make_req());
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            src_server <= '0;
            dst_server <= '0;
        end
        else
        begin
            if (start && !busy)
                route_q.push_back(route_of(src_server, dst_server));
            if (!start || !busy)
            begin
                if (req_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    hop_req_t q;
                    q = req_q.pop_front();
                    start      <= 1'b1;
                    src_server <= q.src;
                    dst_server <= q.dst;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            route_t got;
            route_t want;
            got = '{route_level, switch_index, up_link, down_link, no_route, range_error};
            if (route_q.size() == 0)
                note_fail("unexpected result beat", '0, got);
            else
            begin
                want = route_q.pop_front();
                if (got !== want)
                    note_fail("result mismatch", want, got);
            end
        end
    end

    initial
    begin
        int unsigned radix_set[PHASES];
        int unsigned top_set[PHASES];
        radix_set = '{4, 16, 2, 31, 0, 3, 10, 17, 1, 5};
        top_set   = '{1, 3, 0, 3, 2, 3, 2, 3, 1, 1};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset setting: 2 digits of base 4, servers 0..15
        req_q.push_back('{16'd0, 16'd15});
        req_q.push_back('{16'd15, 16'd0});
        req_q.push_back('{16'd0, 16'd0});
        req_q.push_back('{16'd15, 16'd15});
        req_q.push_back('{16'd16, 16'd0});
        req_q.push_back('{16'd0, 16'd16});
        req_q.push_back('{16'hFFFF, 16'hFFFF});
        req_q.push_back('{16'hFFFF, 16'd0});
        req_q.push_back('{16'd1, 16'd2});
        req_q.push_back('{16'd1, 16'd5});
        req_q.push_back('{16'd5, 16'd1});
        req_q.push_back('{16'd3, 16'd12});

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph != 0)
            begin
                cfg_write(REG_RADIX, radix_set[ph]);
                cfg_write(REG_TOP_LEVEL, top_set[ph]);
            end
            if (ph == 1)
            begin
                req_q.push_back('{16'h0000, 16'hFFFF});
                req_q.push_back('{16'hFFFF, 16'h0000});
                req_q.push_back('{16'hFFFF, 16'hFFFF});
                req_q.push_back('{16'h0000, 16'h0000});
                req_q.push_back('{16'h0001, 16'h0010});
                req_q.push_back('{16'h1234, 16'h1334});
                req_q.push_back('{16'h1234, 16'h2234});
                req_q.push_back('{16'hAAAA, 16'h5555});
            end
            idle_pct = (ph == 2) ? 0 : 10;
            queue_random(PER_PHASE / 2);
            wait_drained();
            queue_random(PER_PHASE - PER_PHASE / 2);
            wait_drained();
        end

        repeat (LATENCY + 8) @(posedge clk);
        if (mismatches == 0 && route_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
